/* hdl/vtte_pkg.sv */
// Package for the virtual timer trap emulator.
// Holds the item types, the outcome codes and the syndrome decode constants.
// No dependencies.
package vtte_pkg;

   typedef enum logic [1:0] {
      OUT_HANDLED = 2'd0,
      OUT_YIELD   = 2'd1,
      OUT_HVC     = 2'd2,
      OUT_HALT    = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [31:0] syndrome;
      logic [63:0] trap_pc;
      logic [63:0] rt_value;
      logic [63:0] x0_value;
      logic [63:0] physical_now;
   } req_type;

   typedef struct packed {
      outcome_type outcome;
      logic [63:0] next_pc;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [63:0] reg_data;
   } rsp_type;

   // Exception classes.
   localparam logic [5:0] EC_WFX    = 6'h01;
   localparam logic [5:0] EC_HVC    = 6'h16;
   localparam logic [5:0] EC_SYSREG = 6'h18;

   // Hypercall immediates.
   localparam logic [15:0] HVC_NOP    = 16'h0060;
   localparam logic [15:0] HVC_REBASE = 16'h0061;

   localparam logic [4:0] RT_ZERO_REG = 5'd31;

   // System register selectors, op0:op1:crn:crm:2'b00 with op2 ORed into the low bits.
   localparam logic [15:0] SEL_PCT   = 16'hCF81;
   localparam logic [15:0] SEL_VCT   = 16'hCF82;
   localparam logic [15:0] SEL_PTVAL = 16'hCF88;
   localparam logic [15:0] SEL_PCTL  = 16'hCF89;
   localparam logic [15:0] SEL_PCVAL = 16'hCF8A;
   localparam logic [15:0] SEL_VTVAL = 16'hCF8C;
   localparam logic [15:0] SEL_VCTL  = 16'hCF8D;
   localparam logic [15:0] SEL_VCVAL = 16'hCF8E;

   localparam logic [63:0] PC_STEP = 64'd4;

   // Control register view: enable and mask bits, plus the status bit.
   function automatic logic [63:0] ctl_view(input logic [1:0] ctl,
                                            input logic [63:0] count,
                                            input logic [63:0] cmp);
      logic status;
      status = ctl[0] && (count >= cmp);
      return {61'd0, status, ctl};
   endfunction

   function automatic logic [63:0] sext32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

endpackage

/* hdl/virtual_timer_trap_emulator_core.sv */
// Virtual timer trap emulator, top level.
// Depends on vtte_pkg, vtte_input_stage, vtte_exec and vtte_output_stage.
//
// Usage:
//   req_ channel: one trap item per handshake (syndrome, trap pc, Rt value,
//   x0 value, physical counter). rsp_ channel: one result item per trap
//   (outcome, resume pc, guest register write-back).
//   Both channels use valid/ready; an item moves when both are high.
//   Path: an accepted trap is held in the input register, then loaded
//   into the result register, from which it is taken on rsp_; a busy
//   result register keeps it waiting in the input register.
//   Throughput: one item per cycle while results are taken. The execute
//   logic between the two registers reads and updates the timer state as
//   the trap moves on, so each trap sees the state left by the one before it.
//   Reset clears the time offset, both timer compares and controls, and
//   empties both registers.
//   When the receiver holds rsp_ready low, the result register keeps its
//   item and the input register holds at most one more trap; req_ready then
//   stays low until the result is taken.
module virtual_timer_trap_emulator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vtte_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vtte_pkg::rsp_type rsp_item
);
   import vtte_pkg::*;

   logic    item_valid;
   req_type item;
   logic    out_free;
   logic    advance;
   rsp_type result;

   assign advance = item_valid && out_free;

   vtte_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vtte_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .item   (item),
      .result (result)
   );

   vtte_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

/* hdl/vtte_input_stage.sv */
// Input register of the trap emulator.
// Holds one accepted trap item until the execute stage takes it; uses vtte_pkg.
module vtte_input_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vtte_pkg::req_type req_item,
   input  logic             advance,
   output logic             item_valid,
   output vtte_pkg::req_type item
);
   import vtte_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/vtte_exec.sv */
// Execute stage of the trap emulator: decodes one trap, updates the timer state
// and forms the result item. Uses vtte_pkg.
module vtte_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  vtte_pkg::req_type item,
   output vtte_pkg::rsp_type result
);
   import vtte_pkg::*;

   logic [63:0] time_offset_ff, time_offset_in;
   logic [63:0] pcmp_hw_ff, pcmp_hw_in;
   logic [63:0] pcmp_virt_ff, pcmp_virt_in;
   logic [1:0]  pctl_ff, pctl_in;
   logic [63:0] vcmp_ff, vcmp_in;
   logic [1:0]  vctl_ff, vctl_in;

   logic [5:0]  ec;
   logic [15:0] imm;
   logic [15:0] sel;
   logic [4:0]  rt;
   logic        rd;
   logic        has_rt;
   logic [63:0] src;
   logic [63:0] vnow;
   logic [63:0] pc_next;
   logic [63:0] rebase_offset;
   logic        known;
   logic [63:0] val;
   logic        rebase;

   assign ec      = item.syndrome[31:26];
   assign imm     = item.syndrome[15:0];
   // op2 bit 2 lands on crm bit 0, as in the selector encoding.
   assign sel     = {item.syndrome[21:8], 2'b00} | {13'd0, item.syndrome[7:5]};
   assign rt      = item.syndrome[4:0];
   assign rd      = item.syndrome[21];
   assign has_rt  = (rt != RT_ZERO_REG);
   assign src     = has_rt ? item.rt_value : 64'd0;
   assign vnow    = item.physical_now + time_offset_ff;
   assign pc_next = item.trap_pc + PC_STEP;
   assign rebase_offset = item.x0_value - item.physical_now;
   assign rebase  = (ec == EC_HVC) && (imm == HVC_REBASE);

   always_comb begin
      time_offset_in = time_offset_ff;
      pcmp_hw_in     = pcmp_hw_ff;
      pcmp_virt_in   = pcmp_virt_ff;
      pctl_in        = pctl_ff;
      vcmp_in        = vcmp_ff;
      vctl_in        = vctl_ff;
      known          = 1'b1;
      val            = 64'd0;

      result.outcome   = OUT_HALT;
      result.next_pc   = item.trap_pc;
      result.reg_write = 1'b0;
      result.reg_index = 5'd0;
      result.reg_data  = 64'd0;

      priority if (ec == EC_WFX) begin
         result.outcome = OUT_YIELD;
         result.next_pc = pc_next;
      end else if (ec == EC_HVC) begin
         if (imm == HVC_NOP) begin
            result.outcome = OUT_HVC;
         end else if (rebase) begin
            time_offset_in   = rebase_offset;
            pcmp_hw_in       = pcmp_virt_ff - rebase_offset;
            result.outcome   = OUT_HVC;
            result.reg_write = 1'b1;
            result.reg_data  = item.x0_value;
         end
      end else if (ec == EC_SYSREG) begin
         unique case (sel)
            SEL_PCT, SEL_VCT: begin
               val = vnow;
            end
            SEL_PCVAL: begin
               if (rd) begin
                  val          = pcmp_hw_ff + time_offset_ff;
                  pcmp_virt_in = pcmp_hw_ff + time_offset_ff;
               end else begin
                  pcmp_virt_in = src;
                  pcmp_hw_in   = src - time_offset_ff;
               end
            end
            SEL_PCTL: begin
               if (rd) begin
                  val = ctl_view(pctl_ff, item.physical_now, pcmp_hw_ff);
               end else begin
                  pctl_in = src[1:0];
               end
            end
            SEL_PTVAL: begin
               if (rd) begin
                  val = pcmp_virt_ff - vnow;
               end else begin
                  // Hardware compare is virtual compare minus offset, i.e. physical plus delta.
                  pcmp_virt_in = vnow + sext32(src);
                  pcmp_hw_in   = item.physical_now + sext32(src);
               end
            end
            SEL_VCVAL: begin
               if (rd) begin
                  val = vcmp_ff;
               end else begin
                  vcmp_in = src;
               end
            end
            SEL_VCTL: begin
               if (rd) begin
                  val = ctl_view(vctl_ff, vnow, vcmp_ff);
               end else begin
                  vctl_in = src[1:0];
               end
            end
            SEL_VTVAL: begin
               if (rd) begin
                  val = vcmp_ff - vnow;
               end else begin
                  vcmp_in = vnow + sext32(src);
               end
            end
            default: begin
               known = 1'b0;
            end
         endcase
         if (known) begin
            result.outcome = OUT_HANDLED;
            result.next_pc = pc_next;
            if (rd && has_rt) begin
               result.reg_write = 1'b1;
               result.reg_index = rt;
               result.reg_data  = val;
            end
         end
      end else begin
         // Every other exception class halts with no state change.
         result.outcome = OUT_HALT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_offset_ff <= 64'd0;
         pcmp_hw_ff     <= 64'd0;
         pcmp_virt_ff   <= 64'd0;
         pctl_ff        <= 2'd0;
         vcmp_ff        <= 64'd0;
         vctl_ff        <= 2'd0;
      end else if (commit) begin
         time_offset_ff <= time_offset_in;
         pcmp_hw_ff     <= pcmp_hw_in;
         pcmp_virt_ff   <= pcmp_virt_in;
         pctl_ff        <= pctl_in;
         vcmp_ff        <= vcmp_in;
         vctl_ff        <= vctl_in;
      end
   end

`ifndef ASSERT_OFF
   // The two copies of the physical compare always differ by exactly the offset.
   a_pcmp_consistent: assert property (@(posedge clock) disable iff (reset)
      pcmp_hw_ff + time_offset_ff == pcmp_virt_ff)
      else $error("physical timer compare copies disagree");

   // Only a committed rebase hypercall moves the time offset.
   a_offset_only_rebase: assert property (@(posedge clock) disable iff (reset)
      !(commit && rebase) |=> $stable(time_offset_ff))
      else $error("time offset changed outside a rebase hypercall");

   a_write_outcome: assert property (@(posedge clock) disable iff (reset)
      result.reg_write |-> (result.outcome == OUT_HANDLED || result.outcome == OUT_HVC))
      else $error("register write on a yield or halt");

   a_no_write_clean: assert property (@(posedge clock) disable iff (reset)
      !result.reg_write |-> (result.reg_index == 5'd0 && result.reg_data == 64'd0))
      else $error("register fields set without a register write");
`endif

endmodule

/* hdl/vtte_output_stage.sv */
// Result register of the trap emulator.
// Holds one result item until the receiver takes it; uses vtte_pkg.
module vtte_output_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  vtte_pkg::rsp_type result,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vtte_pkg::rsp_type rsp_item
);
   import vtte_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule
